/* rtl/mac_frame_header_parser_macros.svh */
// Assertion macros used by the MAC frame header parser queue.
`ifndef MAC_FRAME_HEADER_PARSER_MACROS_SVH
`define MAC_FRAME_HEADER_PARSER_MACROS_SVH

// Property must hold at every clock edge outside reset.
`define MFHP_ASSERT(lbl, prop, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (prop)) else $error(msg);

// Expression must never be true outside reset.
`define MFHP_ASSERT_NEVER(lbl, expr, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) !(expr)) else $error(msg);

`endif

/* rtl/mfhp_pkg.sv */
// Types, constants and helper functions of the MAC frame header parser.
package mfhp_pkg;

  // Stream widths
  localparam int unsigned IN_TDATA_W  = 8;
  localparam int unsigned OUT_TDATA_W = 192;

  // Front-to-back queue
  localparam int unsigned QUEUE_DEPTH = 2;
  localparam int unsigned PTR_W       = $clog2(QUEUE_DEPTH);
  localparam int unsigned CNT_W       = PTR_W + 1;

  // Frame position counter
  localparam logic [4:0] POS_MAX      = 5'd31;
  localparam logic [4:0] POS_SEQ      = 5'd2;
  localparam logic [4:0] POS_DPAN     = 5'd3;
  localparam logic [4:0] POS_DADDR    = 5'd5;
  localparam logic [4:0] HDR_LEN_MIN  = 5'd3;

  // CRC-16, reflected, taps 15, 10 and 3
  localparam logic [15:0] CRC_TAPS = 16'h8408;

  // Output kind
  localparam logic KIND_PAYLOAD = 1'b0;
  localparam logic KIND_SUMMARY = 1'b1;

  // Decoded address modes
  localparam logic [1:0] MODE_NONE  = 2'd0;
  localparam logic [1:0] MODE_SHORT = 2'd1;
  localparam logic [1:0] MODE_LONG  = 2'd2;

  // Frame status codes
  localparam logic [1:0] STATUS_GOOD     = 2'd0;
  localparam logic [1:0] STATUS_FCS_BAD  = 2'd1;
  localparam logic [1:0] STATUS_TOO_SHORT = 2'd2;

  // Flag bit positions
  localparam int unsigned FLAG_INTRA_PAN = 3;

  typedef struct packed {
    logic [2:0]  frame_type;
    logic [3:0]  flag_bits;
    logic [1:0]  dest_mode;
    logic [1:0]  src_mode;
    logic [7:0]  seq_number;
    logic [15:0] dest_pan;
    logic [63:0] dest_address;
    logic [15:0] src_pan;
    logic [63:0] src_address;
    logic [1:0]  status;
  } summary_t;

  // One queue entry: the results caused by one input beat
  typedef struct packed {
    logic       has_pay;
    logic [7:0] pay_byte;
    logic       has_sum;
    summary_t   sum;
  } entry_t;

  // One byte through the bitwise reflected CRC
  function automatic logic [15:0] crc_byte(input logic [15:0] crc_in, input logic [7:0] b);
    logic [15:0] crc;
    logic        fb;
    crc = crc_in;
    for (int k = 0; k < 8; k++) begin
      fb  = b[k] ^ crc[0];
      crc = {1'b0, crc[15:1]};
      if (fb) begin
        crc = crc ^ CRC_TAPS;
      end
    end
    return crc;
  endfunction

  // Mode field: 2 short, 3 long, 0 or 1 none
  function automatic logic [1:0] decode_mode(input logic [1:0] code);
    return (code == 2'd0) ? MODE_NONE : code - 2'd1;
  endfunction

  function automatic logic [4:0] addr_len(input logic [1:0] mode);
    logic [4:0] len;
    case (mode)
      MODE_SHORT: len = 5'd2;
      MODE_LONG:  len = 5'd8;
      default:    len = 5'd0;
    endcase
    return len;
  endfunction

  // Summary beat, payload byte lane left at zero
  function automatic logic [OUT_TDATA_W-1:0] pack_summary(input summary_t s);
    return {3'b000, s.status, s.src_address, s.src_pan, s.dest_address, s.dest_pan,
            s.seq_number, s.src_mode, s.dest_mode, s.flag_bits, s.frame_type, 8'h00};
  endfunction

  function automatic logic [OUT_TDATA_W-1:0] pack_payload(input logic [7:0] b);
    return {{(OUT_TDATA_W-8){1'b0}}, b};
  endfunction

endpackage

/* rtl/mac_frame_header_parser.sv */
// Top level of the MAC frame header parser.
//
// Input stream: one received frame byte per beat, first frame control byte
// first; tlast marks the final byte of the frame (the second FCS byte).
// Output stream: tuser 0 carries a payload byte, tuser 1 carries the frame
// summary (frame control fields, sequence number, PAN ids, addresses and
// status), which always closes the frame's output.
// Payload leaves two bytes behind the input, so the FCS is never passed on.
// The CRC-16 runs over every byte; status is good when it ends at zero,
// FCS mismatch otherwise, and too short when the frame did not reach the
// header plus the two FCS bytes.
// Throughput: one input byte per cycle while the queue is not full. An accepted
// beat's results are queued, then loaded into the output register once it is free.
// The last byte of a frame can produce a payload and a summary beat; the
// two-entry queue between the parser and the output stage absorbs that.
// If the receiver stalls, the queue fills and tready drops after two entries.
// Reset empties the queue and the output stage and puts the parser at the
// start of a frame.
module mac_frame_header_parser (
  input  logic                             clk_i,
  input  logic                             rst_ni,
  // Input stream
  input  logic                             s_axis_tvalid_i,
  output logic                             s_axis_tready_o,
  input  logic [mfhp_pkg::IN_TDATA_W-1:0]  s_axis_tdata_i,  // [7:0] rx_byte
  input  logic                             s_axis_tlast_i,  // end_of_frame
  // Output stream
  output logic                             m_axis_tvalid_o,
  input  logic                             m_axis_tready_i,
  // [7:0] payload_byte, [10:8] frame_type, [14:11] flag_bits,
  // [16:15] dest_mode, [18:17] src_mode, [26:19] seq_number,
  // [42:27] dest_pan, [106:43] dest_address, [122:107] src_pan,
  // [186:123] src_address, [188:187] status, [191:189] zero
  output logic [mfhp_pkg::OUT_TDATA_W-1:0] m_axis_tdata_o,
  output logic                             m_axis_tuser_o   // kind
);
  import mfhp_pkg::*;

  logic   push;
  entry_t push_entry;
  logic   full;
  logic   pop;
  logic   head_valid;
  entry_t head;

  mfhp_front u_front (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .in_valid_i   (s_axis_tvalid_i),
    .in_byte_i    (s_axis_tdata_i[7:0]),
    .in_last_i    (s_axis_tlast_i),
    .in_ready_o   (s_axis_tready_o),
    .full_i       (full),
    .push_o       (push),
    .push_entry_o (push_entry)
  );

  mfhp_queue u_queue (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .push_i       (push),
    .push_entry_i (push_entry),
    .full_o       (full),
    .pop_i        (pop),
    .head_valid_o (head_valid),
    .head_o       (head)
  );

  mfhp_back u_back (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .head_valid_i (head_valid),
    .head_i       (head),
    .pop_o        (pop),
    .out_valid_o  (m_axis_tvalid_o),
    .out_ready_i  (m_axis_tready_i),
    .out_kind_o   (m_axis_tuser_o),
    .out_data_o   (m_axis_tdata_o)
  );

endmodule

/* rtl/mfhp_front.sv */
// Front end: CRC, header field capture, payload delay and result classification.
module mfhp_front (
  input  logic            clk_i,
  input  logic            rst_ni,
  input  logic            in_valid_i,
  input  logic [7:0]      in_byte_i,
  input  logic            in_last_i,
  output logic            in_ready_o,
  input  logic            full_i,
  output logic            push_o,
  output mfhp_pkg::entry_t push_entry_o
);
  import mfhp_pkg::*;

  logic [4:0]  pos_q, pos_d;
  logic [4:0]  hlen_q, hlen_d;
  logic [4:0]  dend_q, dend_d;
  logic [4:0]  sstart_q, sstart_d;
  logic [2:0]  type_q, type_d;
  logic [3:0]  flags_q, flags_d;
  logic [1:0]  dmode_q, dmode_d;
  logic [1:0]  smode_q, smode_d;
  logic [7:0]  seq_q, seq_d;
  logic [15:0] dpan_q, dpan_d;
  logic [63:0] daddr_q, daddr_d;
  logic [15:0] span_q, span_d;
  logic [63:0] saddr_q, saddr_d;
  logic [15:0] crc_q, crc_d;
  logic [7:0]  dly_q [2];
  logic [7:0]  dly_d [2];

  logic        accept;
  logic        emit;
  logic [1:0]  dm_new, sm_new;
  logic [4:0]  de_new, ss_new;
  logic        span_here;
  logic [4:0]  lane_dpan, lane_daddr, lane_span, lane_saddr;
  logic [1:0]  status;
  entry_t      entry;

  assign in_ready_o = !full_i;
  assign accept     = in_valid_i && !full_i;

  // Address layout from the second frame control byte
  always_comb begin
    dm_new    = decode_mode(in_byte_i[3:2]);
    sm_new    = decode_mode(in_byte_i[7:6]);
    de_new    = (dm_new != MODE_NONE) ? POS_DADDR + addr_len(dm_new) : HDR_LEN_MIN;
    span_here = !flags_q[FLAG_INTRA_PAN] && (sm_new != MODE_NONE);
    ss_new    = de_new + (span_here ? 5'd2 : 5'd0);
  end

  // Byte lanes of the multi-byte fields
  assign lane_dpan  = pos_q - POS_DPAN;
  assign lane_daddr = pos_q - POS_DADDR;
  assign lane_span  = pos_q - dend_q;
  assign lane_saddr = pos_q - sstart_q;

  // Per-beat parse
  always_comb begin
    pos_d    = pos_q;
    hlen_d   = hlen_q;
    dend_d   = dend_q;
    sstart_d = sstart_q;
    type_d   = type_q;
    flags_d  = flags_q;
    dmode_d  = dmode_q;
    smode_d  = smode_q;
    seq_d    = seq_q;
    dpan_d   = dpan_q;
    daddr_d  = daddr_q;
    span_d   = span_q;
    saddr_d  = saddr_q;
    crc_d    = crc_q;
    dly_d    = dly_q;
    emit     = 1'b0;
    status   = STATUS_GOOD;
    entry    = '0;

    if (accept) begin
      crc_d = crc_byte(crc_q, in_byte_i);

      if (pos_q < hlen_q) begin
        // header capture
        if (pos_q == 5'd0) begin
          type_d  = in_byte_i[2:0];
          flags_d = in_byte_i[6:3];
        end else if (pos_q == 5'd1) begin
          dmode_d  = dm_new;
          smode_d  = sm_new;
          dend_d   = de_new;
          sstart_d = ss_new;
          hlen_d   = ss_new + addr_len(sm_new);
        end else if (pos_q == POS_SEQ) begin
          seq_d = in_byte_i;
        end else if ((dmode_q != MODE_NONE) && (pos_q < POS_DADDR)) begin
          dpan_d[{lane_dpan[0], 3'b000} +: 8] = in_byte_i;
        end else if ((dmode_q != MODE_NONE) && (pos_q < dend_q)) begin
          daddr_d[{lane_daddr[2:0], 3'b000} +: 8] = in_byte_i;
        end else if (pos_q < sstart_q) begin
          span_d[{lane_span[0], 3'b000} +: 8] = in_byte_i;
        end else begin
          saddr_d[{lane_saddr[2:0], 3'b000} +: 8] = in_byte_i;
        end
      end else begin
        // payload passes two beats late, holding back the FCS
        emit     = ({1'b0, pos_q} >= ({1'b0, hlen_q} + 6'd2));
        dly_d[1] = dly_q[0];
        dly_d[0] = in_byte_i;
      end

      pos_d = (pos_q == POS_MAX) ? pos_q : pos_q + 5'd1;

      if ({1'b0, pos_q} < ({1'b0, hlen_q} + 6'd1)) begin
        status = STATUS_TOO_SHORT;
      end else if (crc_d != 16'h0000) begin
        status = STATUS_FCS_BAD;
      end

      entry.has_pay          = emit;
      entry.pay_byte         = emit ? dly_q[1] : 8'h00;
      entry.has_sum          = in_last_i;
      entry.sum.frame_type   = type_d;
      entry.sum.flag_bits    = flags_d;
      entry.sum.dest_mode    = dmode_d;
      entry.sum.src_mode     = smode_d;
      entry.sum.seq_number   = seq_d;
      entry.sum.dest_pan     = dpan_d;
      entry.sum.dest_address = daddr_d;
      entry.sum.src_pan      = span_d;
      entry.sum.src_address  = saddr_d;
      entry.sum.status       = status;

      // end of frame: back to start-of-frame state
      if (in_last_i) begin
        pos_d    = 5'd0;
        hlen_d   = HDR_LEN_MIN;
        dend_d   = HDR_LEN_MIN;
        sstart_d = HDR_LEN_MIN;
        type_d   = '0;
        flags_d  = '0;
        dmode_d  = MODE_NONE;
        smode_d  = MODE_NONE;
        seq_d    = '0;
        dpan_d   = '0;
        daddr_d  = '0;
        span_d   = '0;
        saddr_d  = '0;
        crc_d    = '0;
        dly_d[0] = '0;
        dly_d[1] = '0;
      end
    end
  end

  assign push_o       = accept && (emit || in_last_i);
  assign push_entry_o = entry;

  // Parser state
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      pos_q    <= 5'd0;
      hlen_q   <= HDR_LEN_MIN;
      dend_q   <= HDR_LEN_MIN;
      sstart_q <= HDR_LEN_MIN;
      type_q   <= '0;
      flags_q  <= '0;
      dmode_q  <= MODE_NONE;
      smode_q  <= MODE_NONE;
      seq_q    <= '0;
      dpan_q   <= '0;
      daddr_q  <= '0;
      span_q   <= '0;
      saddr_q  <= '0;
      crc_q    <= '0;
      dly_q[0] <= '0;
      dly_q[1] <= '0;
    end else begin
      pos_q    <= pos_d;
      hlen_q   <= hlen_d;
      dend_q   <= dend_d;
      sstart_q <= sstart_d;
      type_q   <= type_d;
      flags_q  <= flags_d;
      dmode_q  <= dmode_d;
      smode_q  <= smode_d;
      seq_q    <= seq_d;
      dpan_q   <= dpan_d;
      daddr_q  <= daddr_d;
      span_q   <= span_d;
      saddr_q  <= saddr_d;
      crc_q    <= crc_d;
      dly_q    <= dly_d;
    end
  end

endmodule

/* rtl/mfhp_queue.sv */
// Two-entry queue between the parser front end and the output back end.
module mfhp_queue (
  input  logic             clk_i,
  input  logic             rst_ni,
  input  logic             push_i,
  input  mfhp_pkg::entry_t push_entry_i,
  output logic             full_o,
  input  logic             pop_i,
  output logic             head_valid_o,
  output mfhp_pkg::entry_t head_o
);
  import mfhp_pkg::*;

  entry_t           mem_q [QUEUE_DEPTH];
  logic [PTR_W-1:0] wr_ptr_q, wr_ptr_d;
  logic [PTR_W-1:0] rd_ptr_q, rd_ptr_d;
  logic [CNT_W-1:0] count_q, count_d;
  logic             do_push, do_pop;

  assign full_o       = (count_q == CNT_W'(QUEUE_DEPTH));
  assign head_valid_o = (count_q != '0);
  assign head_o       = mem_q[rd_ptr_q];

  assign do_push = push_i && !full_o;
  assign do_pop  = pop_i && head_valid_o;

  // Pointer and fill bookkeeping
  always_comb begin
    wr_ptr_d = do_push ? wr_ptr_q + PTR_W'(1) : wr_ptr_q;
    rd_ptr_d = do_pop ? rd_ptr_q + PTR_W'(1) : rd_ptr_q;
    count_d  = count_q + CNT_W'(do_push) - CNT_W'(do_pop);
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_ptr_q <= '0;
      rd_ptr_q <= '0;
      count_q  <= '0;
    end else begin
      wr_ptr_q <= wr_ptr_d;
      rd_ptr_q <= rd_ptr_d;
      count_q  <= count_d;
    end
  end

  // Entry storage
  always_ff @(posedge clk_i) begin
    if (do_push) begin
      mem_q[wr_ptr_q] <= push_entry_i;
    end
  end

`include "mac_frame_header_parser_macros.svh"

  `MFHP_ASSERT_NEVER(a_no_overflow, push_i && full_o, "push into a full queue")
  `MFHP_ASSERT_NEVER(a_no_underflow, pop_i && !head_valid_o, "pop from an empty queue")
  `MFHP_ASSERT(a_count_bound, count_q <= CNT_W'(QUEUE_DEPTH), "queue fill count out of range")
  `MFHP_ASSERT(a_entry_nonempty, push_i |-> (push_entry_i.has_pay || push_entry_i.has_sum),
               "queue entry carries no result")

endmodule

/* rtl/mfhp_back.sv */
// Back end: turns queue entries into output beats through a registered stage.
module mfhp_back (
  input  logic                                clk_i,
  input  logic                                rst_ni,
  input  logic                                head_valid_i,
  input  mfhp_pkg::entry_t                    head_i,
  output logic                                pop_o,
  output logic                                out_valid_o,
  input  logic                                out_ready_i,
  output logic                                out_kind_o,
  output logic [mfhp_pkg::OUT_TDATA_W-1:0]    out_data_o
);
  import mfhp_pkg::*;

  logic                   valid_q, valid_d;
  logic                   kind_q, kind_d;
  logic [OUT_TDATA_W-1:0] data_q, data_d;
  logic                   phase_q, phase_d;
  logic                   load;
  logic                   beat_is_pay;
  logic                   entry_done;

  // Payload beat goes first, then the summary of the same entry
  assign load        = !valid_q || out_ready_i;
  assign beat_is_pay = head_i.has_pay && !phase_q;
  assign entry_done  = beat_is_pay ? !head_i.has_sum : 1'b1;
  assign pop_o       = load && head_valid_i && entry_done;

  always_comb begin
    valid_d = valid_q;
    kind_d  = kind_q;
    data_d  = data_q;
    phase_d = phase_q;
    if (load) begin
      valid_d = head_valid_i;
      if (head_valid_i) begin
        kind_d  = beat_is_pay ? KIND_PAYLOAD : KIND_SUMMARY;
        data_d  = beat_is_pay ? pack_payload(head_i.pay_byte) : pack_summary(head_i.sum);
        phase_d = !entry_done;
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= 1'b0;
      phase_q <= 1'b0;
    end else begin
      valid_q <= valid_d;
      phase_q <= phase_d;
    end
  end

  // Output beat registers
  always_ff @(posedge clk_i) begin
    kind_q <= kind_d;
    data_q <= data_d;
  end

  assign out_valid_o = valid_q;
  assign out_kind_o  = kind_q;
  assign out_data_o  = data_q;

endmodule
